### rtl/immp_pkg.sv
package immp_pkg;

    localparam int MAX_WIDTH = 2048;
    localparam int MAX_STEP  = 16;
    localparam int MAX_HEIGHT = 4096;

    localparam int PIX_W   = 8;
    localparam int STEP_W  = 5;
    localparam int WIDTH_W = 12;
    localparam int HGT_W   = 13;
    localparam int DATA_W  = 13;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int PHASE_W = $clog2(MAX_STEP);
    localparam int SUM_W   = 14;

    localparam logic [STEP_W-1:0]  STEP_RST   = STEP_W'(4);
    localparam logic [WIDTH_W-1:0] WIDTH_RST  = WIDTH_W'(640);
    localparam logic [HGT_W-1:0]   HEIGHT_RST = HGT_W'(480);

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;
    localparam logic [PIX_W-1:0] PIX_MIN = 8'd0;

    typedef enum logic [1:0] {
        REG_POOL_STEP    = 2'd0,
        REG_POOL_MODE    = 2'd1,
        REG_FRAME_WIDTH  = 2'd2,
        REG_FRAME_HEIGHT = 2'd3
    } cfg_index_t;

    typedef enum logic {
        MODE_MAX = 1'b0,
        MODE_MIN = 1'b1
    } pool_mode_t;

    function automatic logic [PIX_W-1:0] mode_identity(input pool_mode_t mode);
        return (mode == MODE_MIN) ? PIX_MAX : PIX_MIN;
    endfunction

    function automatic logic [PIX_W-1:0] pool_fold(input logic [PIX_W-1:0] a,
                                                   input logic [PIX_W-1:0] b,
                                                   input pool_mode_t mode);
        if (mode == MODE_MIN)
        begin
            return (a < b) ? a : b;
        end
        return (a > b) ? a : b;
    endfunction

endpackage

### rtl/immp_pix_if.sv
interface immp_pix_if import immp_pkg::*;;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

### rtl/immp_res_if.sv
interface immp_res_if import immp_pkg::*;;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pooled_value;
    logic             row_end;
    logic             frame_end;

    modport source (output valid, output pooled_value, output row_end, output frame_end,
                    input ready);
    modport sink   (input valid, input pooled_value, input row_end, input frame_end,
                    output ready);
endinterface

### rtl/immp_cfg_if.sv
interface immp_cfg_if import immp_pkg::*;;
    logic              valid;
    logic              ready;
    cfg_index_t        index;
    logic [DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/image_max_min_pooling.sv
// channel | dir | request                                  | accepted when
// pix     | in  | pixel, raster order                      | pix.valid && pix.ready
// res     | out | pooled_value, row_end, frame_end         | res.valid && res.ready
// cfg     | in  | index, data (register write)             | cfg.valid && cfg.ready
//
// One pixel per clock unless the output stalls; a result passes stage 1, then the output register.
// The line store is a 2048x8 single-port-per-direction RAM: read at a box end, written
// back from the pipeline register when that stage moves on (read-modify-write).
// rst_n clears positions and valid flags and loads the config defaults; the line store is not cleared.
// pix.ready drops only while a result sits in the output register and another is waiting.
module image_max_min_pooling import immp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    immp_pix_if.sink   pix,
    immp_res_if.source res,
    immp_cfg_if.sink   cfg
);

    logic [STEP_W-1:0]  pool_step_reg, pool_step_next;
    pool_mode_t         pool_mode_reg, pool_mode_next;
    logic [WIDTH_W-1:0] frame_width_reg, frame_width_next;
    logic [HGT_W-1:0]   frame_height_reg, frame_height_next;

    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [PHASE_W-1:0] bcp_reg, bcp_next;
    logic [PHASE_W-1:0] brp_reg, brp_next;
    logic [COL_W-1:0]   ocol_reg, ocol_next;
    logic [PIX_W-1:0]   extreme_reg, extreme_next;

    logic               s1_valid_reg, s1_valid_next;
    logic [PIX_W-1:0]   s1_extreme_reg;
    logic [COL_W-1:0]   s1_idx_reg;
    logic               s1_first_reg;
    logic               s1_out_reg;
    logic               s1_row_end_reg;
    logic               s1_frame_end_reg;

    logic               out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]   out_value_reg;
    logic               out_row_end_reg;
    logic               out_frame_end_reg;

    logic [PIX_W-1:0]   line_mem [MAX_WIDTH];
    logic [PIX_W-1:0]   rd_data_reg;

    logic [STEP_W-1:0]  s_eff;
    logic [WIDTH_W-1:0] w_eff;
    logic [HGT_W-1:0]   h_eff;
    logic               cfg_wr;
    logic               accept;
    logic               col_ok;
    logic               row_ok;
    logic               in_box;
    logic               box_done;
    logic               last_col;
    logic               last_row;
    logic [PIX_W-1:0]   extreme_fold;
    logic [PIX_W-1:0]   ident;
    logic               s1_adv;
    logic [PIX_W-1:0]   s1_value;

    always_comb
    begin
        if (pool_step_reg == '0)
            s_eff = STEP_W'(1);
        else if (pool_step_reg > STEP_W'(MAX_STEP))
            s_eff = STEP_W'(MAX_STEP);
        else
            s_eff = pool_step_reg;

        if (frame_width_reg == '0)
            w_eff = WIDTH_W'(1);
        else if (frame_width_reg > WIDTH_W'(MAX_WIDTH))
            w_eff = WIDTH_W'(MAX_WIDTH);
        else
            w_eff = frame_width_reg;

        if (frame_height_reg == '0)
            h_eff = HGT_W'(1);
        else if (frame_height_reg > HGT_W'(MAX_HEIGHT))
            h_eff = HGT_W'(MAX_HEIGHT);
        else
            h_eff = frame_height_reg;
    end

    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid && cfg.ready;

    // stage 1 moves unless it carries a result and the output register is blocked
    assign s1_adv    = s1_valid_reg && (!s1_out_reg || !out_valid_reg || res.ready);
    assign pix.ready = !s1_valid_reg || s1_adv;
    assign accept    = pix.valid && pix.ready;

    // a box is whole when its first column/row plus the step stays inside the frame
    assign col_ok = (bcp_reg != '0) ||
                    ((SUM_W'(col_reg) + SUM_W'(s_eff)) <= SUM_W'(w_eff));
    assign row_ok = (SUM_W'(row_reg) - SUM_W'(brp_reg) + SUM_W'(s_eff)) <= SUM_W'(h_eff);
    assign in_box = col_ok && row_ok;
    assign box_done = in_box && ((STEP_W'(bcp_reg) + STEP_W'(1)) == s_eff);
    assign last_col = (SUM_W'(col_reg) + SUM_W'(1) + SUM_W'(s_eff)) > SUM_W'(w_eff);
    assign last_row = (SUM_W'(row_reg) + SUM_W'(1) + SUM_W'(s_eff)) > SUM_W'(h_eff);
    assign ident    = mode_identity(pool_mode_reg);
    assign extreme_fold = pool_fold(extreme_reg, pix.pixel, pool_mode_reg);

    always_comb
    begin
        pool_step_next    = pool_step_reg;
        pool_mode_next    = pool_mode_reg;
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        bcp_next     = bcp_reg;
        brp_next     = brp_reg;
        ocol_next    = ocol_reg;
        extreme_next = extreme_reg;

        if (cfg_wr)
        begin
            unique case (cfg.index)
                REG_POOL_STEP:    pool_step_next    = cfg.data[STEP_W-1:0];
                REG_POOL_MODE:    pool_mode_next    = pool_mode_t'(cfg.data[0]);
                REG_FRAME_WIDTH:  frame_width_next  = cfg.data[WIDTH_W-1:0];
                REG_FRAME_HEIGHT: frame_height_next = cfg.data[HGT_W-1:0];
                default:          pool_mode_next    = pool_mode_reg;
            endcase
            col_next     = '0;
            row_next     = '0;
            bcp_next     = '0;
            brp_next     = '0;
            ocol_next    = '0;
            extreme_next = mode_identity(pool_mode_next);
        end
        else if (accept)
        begin
            if (in_box)
            begin
                if (box_done)
                begin
                    extreme_next = ident;
                    bcp_next     = '0;
                    ocol_next    = ocol_reg + COL_W'(1);
                end
                else
                begin
                    extreme_next = extreme_fold;
                    bcp_next     = bcp_reg + PHASE_W'(1);
                end
            end

            if ((SUM_W'(col_reg) + SUM_W'(1)) >= SUM_W'(w_eff))
            begin
                col_next     = '0;
                bcp_next     = '0;
                ocol_next    = '0;
                extreme_next = ident;
                if ((SUM_W'(row_reg) + SUM_W'(1)) >= SUM_W'(h_eff))
                begin
                    row_next = '0;
                    brp_next = '0;
                end
                else
                begin
                    row_next = row_reg + ROW_W'(1);
                    if ((STEP_W'(brp_reg) + STEP_W'(1)) >= s_eff)
                        brp_next = '0;
                    else
                        brp_next = brp_reg + PHASE_W'(1);
                end
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_comb
    begin
        if (accept)
            s1_valid_next = box_done;
        else if (s1_adv)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (s1_adv && s1_out_reg)
            out_valid_next = 1'b1;
        else if (res.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_step_reg    <= STEP_RST;
            pool_mode_reg    <= MODE_MAX;
            frame_width_reg  <= WIDTH_RST;
            frame_height_reg <= HEIGHT_RST;
            col_reg       <= '0;
            row_reg       <= '0;
            bcp_reg       <= '0;
            brp_reg       <= '0;
            ocol_reg      <= '0;
            extreme_reg   <= PIX_MIN;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pool_step_reg    <= pool_step_next;
            pool_mode_reg    <= pool_mode_next;
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            bcp_reg       <= bcp_next;
            brp_reg       <= brp_next;
            ocol_reg      <= ocol_next;
            extreme_reg   <= extreme_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // stage 1 payload; line store read issued with it
    always_ff @(posedge clk)
    begin
        if (accept && box_done)
        begin
            s1_extreme_reg   <= extreme_fold;
            s1_idx_reg       <= ocol_reg;
            s1_first_reg     <= (brp_reg == '0);
            s1_out_reg       <= ((STEP_W'(brp_reg) + STEP_W'(1)) == s_eff);
            s1_row_end_reg   <= last_col;
            s1_frame_end_reg <= last_col && last_row;
            rd_data_reg      <= line_mem[ocol_reg];
        end
    end

    // an entry is rewritten at least one row after its last write, so no bypass is needed
    assign s1_value = s1_first_reg ? s1_extreme_reg
                                   : pool_fold(rd_data_reg, s1_extreme_reg, pool_mode_reg);

    always_ff @(posedge clk)
    begin
        if (s1_adv)
            line_mem[s1_idx_reg] <= s1_value;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_out_reg)
        begin
            out_value_reg     <= s1_value;
            out_row_end_reg   <= s1_row_end_reg;
            out_frame_end_reg <= s1_frame_end_reg;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.pooled_value = out_value_reg;
    assign res.row_end      = out_row_end_reg;
    assign res.frame_end    = out_frame_end_reg;

endmodule

### rtl/immp_checker.sv
module immp_checker import immp_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             pix_valid,
    input logic             pix_ready,
    input logic             res_valid,
    input logic             res_ready,
    input logic [PIX_W-1:0] res_pooled_value,
    input logic             res_row_end,
    input logic             res_frame_end
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_pooled_value))
        else $error("result dropped or changed while stalled");

    a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !res_frame_end || res_row_end)
        else $error("frame end without row end");

    // a fresh result must trace back to an accepted pixel, the one that closed its box
    a_res_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(pix_valid && pix_ready, 2))
        else $error("result without a preceding pixel");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !pix_ready |-> res_valid && !res_ready)
        else $error("input stalled while output is free");

endmodule

bind image_max_min_pooling immp_checker u_immp_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .pix_valid        (pix.valid),
    .pix_ready        (pix.ready),
    .res_valid        (res.valid),
    .res_ready        (res.ready),
    .res_pooled_value (res.pooled_value),
    .res_row_end      (res.row_end),
    .res_frame_end    (res.frame_end)
);
